[rtl/core/spot_pkg.sv]
// Shared types and constants for the shape pair overlap test.
// Used by spot_front, spot_queue, spot_back and the top level.
package spot_pkg;

    localparam int SIZE_BITS      = 18;
    localparam int COORD_BITS_DEF = 20;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int QUEUE_DEPTH    = 4;

    // pair classes
    localparam logic [1:0] CLS_CC = 2'd0;  // circle against circle
    localparam logic [1:0] CLS_RR = 2'd1;  // rectangle against rectangle
    localparam logic [1:0] CLS_CR = 2'd2;  // circle against rectangle

    // classified work handed from front to back
    typedef struct packed {
        logic sq;    // result comes from m1^2 + m2^2 < m3^2
        logic flag;  // result when sq is low
    } t_cls;

    // signed width that holds every edge, center and difference
    function automatic int pos_width(input int coord_bits);
        int base;
        begin
            base = (coord_bits > SIZE_BITS + 2) ? coord_bits : SIZE_BITS + 2;
            return base + 2;
        end
    endfunction

endpackage

[rtl/core/shape_pair_overlap_test_top.sv]
// Shape pair overlap test: circle/rectangle pairs in, one overlap beat out.
// Path: front register, queue entry, then the back end's three pipeline stages.
// Throughput: one beat per cycle while the output is not stalled; the front and back
// ends meet at a 4-entry queue; back-end squaring uses 11x11 multipliers at 20-bit coords.
// Reset: synchronous, active low; clears all valid and queue state, nothing to sweep.
module shape_pair_overlap_test_top #(
    parameter int COORD_BITS = spot_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spot_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_a_kind,
    input  logic signed [COORD_BITS-1:0]   i_a_left,
    input  logic signed [COORD_BITS-1:0]   i_a_top,
    input  logic [spot_pkg::SIZE_BITS-1:0] i_a_size_x,
    input  logic [spot_pkg::SIZE_BITS-1:0] i_a_size_y,
    input  logic                           i_b_kind,
    input  logic signed [COORD_BITS-1:0]   i_b_left,
    input  logic signed [COORD_BITS-1:0]   i_b_top,
    input  logic [spot_pkg::SIZE_BITS-1:0] i_b_size_x,
    input  logic [spot_pkg::SIZE_BITS-1:0] i_b_size_y,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_overlap
);

    localparam int MAG_W = spot_pkg::pos_width(COORD_BITS);

    logic             w_q_full, w_push, w_q_valid, w_pop;
    spot_pkg::t_cls   w_f_cls, w_b_cls;
    logic [MAG_W-1:0] w_f_m1, w_f_m2, w_f_m3;
    logic [MAG_W-1:0] w_b_m1, w_b_m2, w_b_m3;

    spot_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .MAG_W      (MAG_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_a_kind   (i_a_kind),
        .i_a_left   (i_a_left),
        .i_a_top    (i_a_top),
        .i_a_size_x (i_a_size_x),
        .i_a_size_y (i_a_size_y),
        .i_b_kind   (i_b_kind),
        .i_b_left   (i_b_left),
        .i_b_top    (i_b_top),
        .i_b_size_x (i_b_size_x),
        .i_b_size_y (i_b_size_y),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cls      (w_f_cls),
        .o_m1       (w_f_m1),
        .o_m2       (w_f_m2),
        .o_m3       (w_f_m3)
    );

    spot_queue #(
        .MAG_W (MAG_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cls   (w_f_cls),
        .i_m1    (w_f_m1),
        .i_m2    (w_f_m2),
        .i_m3    (w_f_m3),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cls   (w_b_cls),
        .o_m1    (w_b_m1),
        .o_m2    (w_b_m2),
        .o_m3    (w_b_m3)
    );

    spot_back #(
        .MAG_W (MAG_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_pop     (w_pop),
        .i_cls     (w_b_cls),
        .i_m1      (w_b_m1),
        .i_m2      (w_b_m2),
        .i_m3      (w_b_m3),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_overlap (o_overlap)
    );

endmodule

[rtl/core/spot_front.sv]
// Front end: accepts a shape pair, forms edges and centers, classifies it.
// Depends on spot_pkg; feeds spot_queue.
module spot_front #(
    parameter int COORD_BITS = spot_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spot_pkg::FRAC_BITS_DEF,
    parameter int MAG_W      = spot_pkg::pos_width(spot_pkg::COORD_BITS_DEF)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_a_kind,
    input  logic signed [COORD_BITS-1:0]        i_a_left,
    input  logic signed [COORD_BITS-1:0]        i_a_top,
    input  logic [spot_pkg::SIZE_BITS-1:0]      i_a_size_x,
    input  logic [spot_pkg::SIZE_BITS-1:0]      i_a_size_y,
    input  logic                                i_b_kind,
    input  logic signed [COORD_BITS-1:0]        i_b_left,
    input  logic signed [COORD_BITS-1:0]        i_b_top,
    input  logic [spot_pkg::SIZE_BITS-1:0]      i_b_size_x,
    input  logic [spot_pkg::SIZE_BITS-1:0]      i_b_size_y,
    input  logic                                i_q_full,
    output logic                                o_push,
    output spot_pkg::t_cls                      o_cls,
    output logic [MAG_W-1:0]                    o_m1,
    output logic [MAG_W-1:0]                    o_m2,
    output logic [MAG_W-1:0]                    o_m3
);

    localparam int W  = MAG_W;
    localparam int SB = spot_pkg::SIZE_BITS;

    // operand select: p is the circle of a mixed pair
    logic                         w_swap;
    logic [1:0]                   w_cls;
    logic signed [COORD_BITS-1:0] w_p_left, w_p_top, w_q_left, w_q_top;
    logic [SB-1:0]                w_p_sx, w_p_sy, w_q_sx, w_q_sy;
    logic                         w_load;

    logic                r_valid;
    logic [1:0]          r_cls;
    logic signed [W-1:0] r_p_left, r_p_top, r_p_right, r_p_bot, r_p_cy, r_p_xr, r_p_yb;
    logic [SB-1:0]       r_p_rad;
    logic signed [W-1:0] r_q_left, r_q_top, r_q_right, r_q_bot, r_q_cy;
    logic [SB:0]         r_rsum;

    // classification stage signals
    logic signed [W-1:0] w_dxa, w_dxb, w_dya, w_dyb;
    logic signed [W-1:0] w_lcx, w_tcy, w_bcy, w_cyb;
    logic [W-1:0]        w_adx, w_ady, w_ex, w_ey, w_bmag;
    logic                w_inx, w_iny, w_side_x, w_side_y, w_rr;

    always_comb begin
        w_swap   = i_a_kind & ~i_b_kind;
        w_p_left = w_swap ? i_b_left   : i_a_left;
        w_p_top  = w_swap ? i_b_top    : i_a_top;
        w_p_sx   = w_swap ? i_b_size_x : i_a_size_x;
        w_p_sy   = w_swap ? i_b_size_y : i_a_size_y;
        w_q_left = w_swap ? i_a_left   : i_b_left;
        w_q_top  = w_swap ? i_a_top    : i_b_top;
        w_q_sx   = w_swap ? i_a_size_x : i_b_size_x;
        w_q_sy   = w_swap ? i_a_size_y : i_b_size_y;
        if (!i_a_kind && !i_b_kind) begin
            w_cls = spot_pkg::CLS_CC;
        end else if (i_a_kind && i_b_kind) begin
            w_cls = spot_pkg::CLS_RR;
        end else begin
            w_cls = spot_pkg::CLS_CR;
        end
    end

    assign o_stall = r_valid && i_q_full;
    assign o_push  = r_valid && !i_q_full;
    assign w_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cls     <= w_cls;
            r_p_left  <= W'(w_p_left);
            r_p_top   <= W'(w_p_top);
            r_p_right <= W'(w_p_left) + W'(w_p_sx);
            r_p_bot   <= W'(w_p_top) + W'(w_p_sy);
            r_p_cy    <= W'(w_p_top) + W'(w_p_sx);
            r_p_xr    <= W'(w_p_left) + (W'(w_p_sx) << 1);
            r_p_yb    <= W'(w_p_top) + (W'(w_p_sx) << 1);
            r_p_rad   <= w_p_sx;
            r_q_left  <= W'(w_q_left);
            r_q_top   <= W'(w_q_top);
            r_q_right <= W'(w_q_left) + W'(w_q_sx);
            r_q_bot   <= W'(w_q_top) + W'(w_q_sy);
            r_q_cy    <= W'(w_q_top) + W'(w_q_sx);
            r_rsum    <= (SB+1)'(w_p_sx) + (SB+1)'(w_q_sx);
        end
    end

    // differences, taken both ways so the magnitude is a select
    always_comb begin
        w_dxa = r_q_right - r_p_right;
        w_dxb = r_p_right - r_q_right;
        w_dya = r_q_cy - r_p_cy;
        w_dyb = r_p_cy - r_q_cy;
        w_lcx = r_q_left - r_p_right;
        w_tcy = r_q_top - r_p_cy;
        w_bcy = r_q_bot - r_p_cy;
        w_cyb = r_p_cy - r_q_bot;
        w_adx = w_dxa[W-1] ? w_dxb : w_dxa;
        w_ady = w_dya[W-1] ? w_dyb : w_dya;
        w_bmag = w_bcy[W-1] ? w_cyb : w_bcy;
        // nearest corner: left/top edge when the center is before it
        w_ex  = (r_p_right < r_q_left) ? w_lcx : w_adx;
        w_ey  = (r_p_cy < r_q_top)     ? w_tcy : w_bmag;
        w_inx = (r_p_right > r_q_left) && (r_p_right < r_q_right);
        w_iny = (r_p_cy > r_q_top) && (r_p_cy < r_q_bot);
        w_side_x = (r_p_yb > r_q_top) && (r_p_top < r_q_bot);
        w_side_y = (r_p_xr > r_q_left) && (r_p_left < r_q_right);
        w_rr  = (r_p_left < r_q_right) && (r_p_right > r_q_left) &&
                (r_p_top < r_q_bot) && (r_p_bot > r_q_top);
    end

    always_comb begin
        case (r_cls)
            spot_pkg::CLS_CC: begin
                o_cls.sq   = 1'b1;
                o_cls.flag = 1'b0;
                o_m1       = w_adx >> FRAC_BITS;
                o_m2       = w_ady >> FRAC_BITS;
                o_m3       = W'(r_rsum >> FRAC_BITS);
            end
            spot_pkg::CLS_CR: begin
                o_cls.sq   = !w_inx && !w_iny;
                o_cls.flag = w_inx ? w_side_x : w_side_y;
                o_m1       = w_ex;
                o_m2       = w_ey;
                o_m3       = W'(r_p_rad);
            end
            default: begin
                o_cls.sq   = 1'b0;
                o_cls.flag = w_rr;
                o_m1       = '0;
                o_m2       = '0;
                o_m3       = '0;
            end
        endcase
    end

endmodule

[rtl/core/spot_queue.sv]
// Short queue of classified work between the front and back ends.
// Depends on spot_pkg for its depth and the class struct.
module spot_queue #(
    parameter int MAG_W = spot_pkg::pos_width(spot_pkg::COORD_BITS_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  spot_pkg::t_cls     i_cls,
    input  logic [MAG_W-1:0]   i_m1,
    input  logic [MAG_W-1:0]   i_m2,
    input  logic [MAG_W-1:0]   i_m3,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output spot_pkg::t_cls     o_cls,
    output logic [MAG_W-1:0]   o_m1,
    output logic [MAG_W-1:0]   o_m2,
    output logic [MAG_W-1:0]   o_m3
);

    localparam int DEPTH = spot_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = $bits(spot_pkg::t_cls) + 3 * MAG_W;

    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic [ENT_W-1:0] w_rd_ent;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign w_rd_ent = r_mem[r_rd];
    assign {o_cls, o_m1, o_m2, o_m3} = w_rd_ent;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= {i_cls, i_m1, i_m2, i_m3};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/spot_back.sv]
// Back end: squares three magnitudes from split partial products, sums
// and compares them (or takes the flag); the output register holds it.
module spot_back #(
    parameter int MAG_W = spot_pkg::pos_width(spot_pkg::COORD_BITS_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_pop,
    input  spot_pkg::t_cls     i_cls,
    input  logic [MAG_W-1:0]   i_m1,
    input  logic [MAG_W-1:0]   i_m2,
    input  logic [MAG_W-1:0]   i_m3,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_overlap
);

    localparam int H    = (MAG_W + 1) / 2;
    localparam int HI_W = MAG_W - H;
    localparam int SQ_W = 2 * MAG_W;

    logic [MAG_W-1:0] w_m  [3];
    logic [H-1:0]     w_lo [3];
    logic [HI_W-1:0]  w_hi [3];
    logic             w_mv1, w_mv2, w_mv3;

    logic             r_b1_valid, r_b2_valid, r_out_valid;
    spot_pkg::t_cls   r_b1_cls, r_b2_cls;
    logic [2*H-1:0]    r_pp_ll [3];
    logic [MAG_W-1:0]  r_pp_hl [3];
    logic [2*HI_W-1:0] r_pp_hh [3];
    logic [SQ_W-1:0]   r_sq    [3];
    logic              r_overlap;

    always_comb begin
        w_m[0] = i_m1;
        w_m[1] = i_m2;
        w_m[2] = i_m3;
        for (int k = 0; k < 3; k++) begin
            w_lo[k] = w_m[k][H-1:0];
            w_hi[k] = w_m[k][MAG_W-1:H];
        end
    end

    // advance each stage when the one after it frees up
    assign w_mv3 = !r_out_valid || !i_stall;
    assign w_mv2 = !r_b2_valid || w_mv3;
    assign w_mv1 = !r_b1_valid || w_mv2;
    assign o_pop = i_q_valid && w_mv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_mv1) begin
                r_b1_valid <= i_q_valid;
            end
            if (w_mv2) begin
                r_b2_valid <= r_b1_valid;
            end
            if (w_mv3) begin
                r_out_valid <= r_b2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv1) begin
            r_b1_cls <= i_cls;
            for (int k = 0; k < 3; k++) begin
                r_pp_ll[k] <= (2*H)'(w_lo[k]) * (2*H)'(w_lo[k]);
                r_pp_hl[k] <= MAG_W'(w_hi[k]) * MAG_W'(w_lo[k]);
                r_pp_hh[k] <= (2*HI_W)'(w_hi[k]) * (2*HI_W)'(w_hi[k]);
            end
        end
        if (w_mv2) begin
            r_b2_cls <= r_b1_cls;
            for (int k = 0; k < 3; k++) begin
                // hi^2 and lo^2 do not overlap; cross term counts twice
                r_sq[k] <= {r_pp_hh[k], r_pp_ll[k]} + (SQ_W'(r_pp_hl[k]) << (H + 1));
            end
        end
        if (w_mv3) begin
            r_overlap <= r_b2_cls.sq ?
                         (((SQ_W+1)'(r_sq[0]) + (SQ_W+1)'(r_sq[1])) < (SQ_W+1)'(r_sq[2])) :
                         r_b2_cls.flag;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_overlap = r_overlap;

endmodule

[tb/sv/spot_tb_pkg.sv]
`timescale 1ns / 1ps
// Shape kinds and the shape record shared by the overlap checker and the testbench top.
// Depends on spot_pkg for the coordinate and size widths.
package spot_tb_pkg;

    localparam int COORD_W = spot_pkg::COORD_BITS_DEF;
    localparam int SIZE_W  = spot_pkg::SIZE_BITS;
    localparam int FRAC_W  = spot_pkg::FRAC_BITS_DEF;

    localparam logic KIND_CIRCLE = 1'b0;
    localparam logic KIND_RECT   = 1'b1;

    typedef struct {
        logic                      kind;
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         sx;
        logic [SIZE_W-1:0]         sy;
    } shape_s;

endpackage

[tb/sv/spot_overlap_checker.sv]
`timescale 1ns / 1ps
// Overlap checker: watches both channels of the shape pair block, predicts the flag of
// every accepted pair and compares it with the flag beats in order. Needs spot_tb_pkg.
module spot_overlap_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_pair_valid,
    input  logic                                  i_pair_stall,
    input  logic                                  i_a_kind,
    input  logic signed [spot_tb_pkg::COORD_W-1:0] i_a_left,
    input  logic signed [spot_tb_pkg::COORD_W-1:0] i_a_top,
    input  logic [spot_tb_pkg::SIZE_W-1:0]         i_a_size_x,
    input  logic [spot_tb_pkg::SIZE_W-1:0]         i_a_size_y,
    input  logic                                  i_b_kind,
    input  logic signed [spot_tb_pkg::COORD_W-1:0] i_b_left,
    input  logic signed [spot_tb_pkg::COORD_W-1:0] i_b_top,
    input  logic [spot_tb_pkg::SIZE_W-1:0]         i_b_size_x,
    input  logic [spot_tb_pkg::SIZE_W-1:0]         i_b_size_y,
    input  logic                                  i_flag_valid,
    input  logic                                  i_flag_stall,
    input  logic                                  i_overlap,
    output int                                    o_errors,
    output int                                    o_pending,
    output int                                    o_checked,
    output int                                    o_hits
);
    import spot_tb_pkg::*;

    typedef struct {
        int seq;
        bit flag;
    } due_flag_s;

    due_flag_s due_flags[$];
    due_flag_s oldest;
    shape_s    shape_a;
    shape_s    shape_b;
    int        pair_seq = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
        o_hits    = 0;
    end

    function automatic bit circle_hits_box(input shape_s c, input shape_s r);
        longint rad, cx, cy, lft, top, rgt, bot, ex, ey;
        rad = longint'(c.sx);
        cx  = longint'(c.left) + rad;
        cy  = longint'(c.top) + rad;
        lft = longint'(r.left);
        top = longint'(r.top);
        rgt = lft + longint'(r.sx);
        bot = top + longint'(r.sy);
        // center within one span: plain side test on the other axis
        if (cx > lft && cx < rgt)
            return (cy + rad > top) && (cy - rad < bot);
        if (cy > top && cy < bot)
            return (cx + rad > lft) && (cx - rad < rgt);
        ex = ((cx < lft) ? lft : rgt) - cx;
        ey = ((cy < top) ? top : bot) - cy;
        return ex * ex + ey * ey < rad * rad;
    endfunction

    function automatic bit overlap_of(input shape_s a, input shape_s b);
        longint dx, dy, mx, my, mr;
        if (a.kind == KIND_CIRCLE && b.kind == KIND_CIRCLE) begin
            dx = (longint'(b.left) + longint'(b.sx)) - (longint'(a.left) + longint'(a.sx));
            dy = (longint'(b.top) + longint'(b.sx)) - (longint'(a.top) + longint'(a.sx));
            // drop the fraction toward zero before squaring
            mx = ((dx < 0) ? -dx : dx) >> FRAC_W;
            my = ((dy < 0) ? -dy : dy) >> FRAC_W;
            mr = (longint'(a.sx) + longint'(b.sx)) >> FRAC_W;
            return mx * mx + my * my < mr * mr;
        end
        if (a.kind == KIND_RECT && b.kind == KIND_RECT)
            return longint'(a.left) < longint'(b.left) + longint'(b.sx) &&
                   longint'(a.left) + longint'(a.sx) > longint'(b.left) &&
                   longint'(a.top) < longint'(b.top) + longint'(b.sy) &&
                   longint'(a.top) + longint'(a.sy) > longint'(b.top);
        if (a.kind == KIND_CIRCLE)
            return circle_hits_box(a, b);
        return circle_hits_box(b, a);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: overlap mismatch, %s", $time, what);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_flags.delete();
            o_pending = 0;
        end else begin
            // push before pop so a same-edge pair and flag line up
            if (i_pair_valid && !i_pair_stall) begin
                shape_a = '{i_a_kind, i_a_left, i_a_top, i_a_size_x, i_a_size_y};
                shape_b = '{i_b_kind, i_b_left, i_b_top, i_b_size_x, i_b_size_y};
                due_flags.push_back('{pair_seq, overlap_of(shape_a, shape_b)});
                pair_seq++;
            end
            if (i_flag_valid && !i_flag_stall) begin
                o_checked++;
                if (due_flags.size() == 0) begin
                    report_mismatch("flag beat with no pair outstanding");
                end else begin
                    oldest = due_flags.pop_front();
                    if (i_overlap !== oldest.flag)
                        report_mismatch($sformatf("pair %0d: got %b, want %b",
                                                  oldest.seq, i_overlap, oldest.flag));
                    if (oldest.flag)
                        o_hits++;
                end
            end
            o_pending = due_flags.size();
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench top for shape_pair_overlap_test_top: drives directed and random shape pairs
// with random gaps and output stalls; spot_overlap_checker predicts and compares flags.
module tb;
    import spot_tb_pkg::*;

    localparam int RANDOM_PAIRS = 600;
    // the longest sender gap and the longest stall are far shorter than this limit
    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 20;

    logic                      i_clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      pair_valid = 1'b0;
    logic                      pair_stall;
    logic                      a_kind = 1'b0;
    logic signed [COORD_W-1:0] a_left = '0;
    logic signed [COORD_W-1:0] a_top = '0;
    logic [SIZE_W-1:0]         a_size_x = '0;
    logic [SIZE_W-1:0]         a_size_y = '0;
    logic                      b_kind = 1'b0;
    logic signed [COORD_W-1:0] b_left = '0;
    logic signed [COORD_W-1:0] b_top = '0;
    logic [SIZE_W-1:0]         b_size_x = '0;
    logic [SIZE_W-1:0]         b_size_y = '0;
    logic                      flag_valid;
    logic                      flag_stall = 1'b0;
    logic                      flag;

    int mismatches, pending, checked, hits;
    int circle_pairs = 0, box_pairs = 0, mixed_pairs = 0;
    bit calm = 1'b0;
    int stall_hold = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    shape_pair_overlap_test_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_valid    (pair_valid),
        .o_stall    (pair_stall),
        .i_a_kind   (a_kind),
        .i_a_left   (a_left),
        .i_a_top    (a_top),
        .i_a_size_x (a_size_x),
        .i_a_size_y (a_size_y),
        .i_b_kind   (b_kind),
        .i_b_left   (b_left),
        .i_b_top    (b_top),
        .i_b_size_x (b_size_x),
        .i_b_size_y (b_size_y),
        .o_valid    (flag_valid),
        .i_stall    (flag_stall),
        .o_overlap  (flag)
    );

    spot_overlap_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_pair_valid (pair_valid),
        .i_pair_stall (pair_stall),
        .i_a_kind     (a_kind),
        .i_a_left     (a_left),
        .i_a_top      (a_top),
        .i_a_size_x   (a_size_x),
        .i_a_size_y   (a_size_y),
        .i_b_kind     (b_kind),
        .i_b_left     (b_left),
        .i_b_top      (b_top),
        .i_b_size_x   (b_size_x),
        .i_b_size_y   (b_size_y),
        .i_flag_valid (flag_valid),
        .i_flag_stall (flag_stall),
        .i_overlap    (flag),
        .o_errors     (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    // mostly short idles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic shape_s shp(input logic kind, input int left, input int top,
                                   input int sx, input int sy);
        shape_s s;
        s.kind = kind;
        s.left = COORD_W'(left);
        s.top  = COORD_W'(top);
        s.sx   = SIZE_W'(sx);
        s.sy   = SIZE_W'(sy);
        return s;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        longint lo, hi;
        lo = -(longint'(1) << (COORD_W - 1));
        hi = -lo - 1;
        if (v < lo)
            return COORD_W'(lo);
        if (v > hi)
            return COORD_W'(hi);
        return COORD_W'(v);
    endfunction

    function automatic shape_s make_near(input int cx, input int cy, input int sc);
        shape_s s;
        s.kind = 1'($urandom_range(0, 1));
        s.left = clamp_coord(longint'(cx) + longint'($urandom_range(0, 2 * sc)) -
                             longint'(sc));
        s.top  = clamp_coord(longint'(cy) + longint'($urandom_range(0, 2 * sc)) -
                             longint'(sc));
        s.sx   = SIZE_W'($urandom_range(0, sc));
        s.sy   = SIZE_W'($urandom_range(0, sc));
        return s;
    endfunction

    // output side: random stall bursts, none while calm
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold--;
        end else if (flag_stall || calm) begin
            flag_stall <= 1'b0;
            stall_hold = $urandom_range(0, 12);
        end else begin
            flag_stall <= 1'b1;
            stall_hold = idle_len() - 1;
        end
    end

    task automatic send_shapes(input shape_s a, input shape_s b);
        a_kind     <= a.kind;
        a_left     <= a.left;
        a_top      <= a.top;
        a_size_x   <= a.sx;
        a_size_y   <= a.sy;
        b_kind     <= b.kind;
        b_left     <= b.left;
        b_top      <= b.top;
        b_size_x   <= b.sx;
        b_size_y   <= b.sy;
        pair_valid <= 1'b1;
        do @(posedge i_clk); while (pair_stall);
        if (a.kind == KIND_CIRCLE && b.kind == KIND_CIRCLE)
            circle_pairs++;
        else if (a.kind == KIND_RECT && b.kind == KIND_RECT)
            box_pairs++;
        else
            mixed_pairs++;
    endtask

    task automatic idle_sender();
        int n;
        if (!calm && $urandom_range(0, 99) >= 55) begin
            n = idle_len();
            pair_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every outstanding flag has come back
    task automatic wait_drained();
        pair_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!rst_n || (pair_valid && !pair_stall) || (flag_valid && !flag_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        shape_s a, b, t;
        int pick, sc, cx, cy, reach, d;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // box pairs: overlap, touching edges, empty box inside
        send_shapes(shp(KIND_RECT, 0, 0, 160, 160), shp(KIND_RECT, 80, 80, 160, 160));
        idle_sender();
        send_shapes(shp(KIND_RECT, 0, 0, 160, 160), shp(KIND_RECT, 160, 0, 160, 160));
        idle_sender();
        send_shapes(shp(KIND_RECT, 0, 0, 160, 160), shp(KIND_RECT, 0, 160, 160, 160));
        idle_sender();
        send_shapes(shp(KIND_RECT, 32, 32, 0, 0), shp(KIND_RECT, 0, 0, 160, 160));
        idle_sender();
        // circle pairs: overlap, touching, truncation either way, zero radius
        send_shapes(shp(KIND_CIRCLE, 0, 0, 80, 0), shp(KIND_CIRCLE, 100, 0, 80, 0));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 0, 0, 80, 0), shp(KIND_CIRCLE, 160, 0, 80, 0));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 0, 0, 88, 0), shp(KIND_CIRCLE, 175, 0, 88, 0));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 0, 0, 79, 0), shp(KIND_CIRCLE, 150, 0, 79, 0));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 150, 40, 79, 0), shp(KIND_CIRCLE, 0, 0, 79, 0));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 48, 48, 0, 0), shp(KIND_CIRCLE, 48, 48, 0, 0));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 0, 0, 80, 262143), shp(KIND_CIRCLE, 100, 0, 80, 12345));
        idle_sender();
        // circle against box: side tests, corner tests, center inside, on the edge
        send_shapes(shp(KIND_CIRCLE, 40, -100, 60, 0), shp(KIND_RECT, 0, 0, 200, 200));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 40, -120, 60, 0), shp(KIND_RECT, 0, 0, 200, 200));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, -110, 40, 60, 0), shp(KIND_RECT, 0, 0, 200, 200));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, -150, -150, 100, 0), shp(KIND_RECT, 0, 0, 200, 200));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, -128, -144, 80, 0), shp(KIND_RECT, 0, 0, 200, 200));
        idle_sender();
        send_shapes(shp(KIND_RECT, 0, 0, 200, 200), shp(KIND_CIRCLE, 168, 184, 80, 0));
        idle_sender();
        send_shapes(shp(KIND_RECT, 0, 0, 200, 200), shp(KIND_CIRCLE, 168, 184, 81, 77));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 40, 40, 10, 0), shp(KIND_RECT, 0, 0, 200, 200));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, -60, 40, 60, 0), shp(KIND_RECT, 0, 0, 200, 200));
        idle_sender();
        // field extremes
        send_shapes(shp(KIND_RECT, -524288, -524288, 262143, 262143),
                    shp(KIND_RECT, 524287, 524287, 262143, 262143));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, -524288, -524288, 262143, 262143),
                    shp(KIND_CIRCLE, 524287, 524287, 262143, 262143));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 524287, -524288, 262143, 0),
                    shp(KIND_RECT, -524288, 524287, 262143, 262143));
        idle_sender();
        send_shapes(shp(KIND_RECT, -524288, -524288, 262143, 262143),
                    shp(KIND_CIRCLE, -524288, -524288, 262143, 0));
        idle_sender();
        send_shapes(shp(KIND_CIRCLE, 0, 0, 0, 0), shp(KIND_RECT, 0, 0, 0, 0));
        wait_drained();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            calm <= (n % 150) >= 110;
            if (n == RANDOM_PAIRS / 2)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                // any bit pattern at all
                a = shp(1'($urandom_range(0, 1)), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom));
                b = shp(1'($urandom_range(0, 1)), int'($urandom), int'($urandom),
                        int'($urandom), int'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    sc = $urandom_range(16, 1023);
                else if (pick < 90)
                    sc = $urandom_range(1024, 32767);
                else
                    sc = $urandom_range(32768, 262143);
                cx = int'($urandom_range(0, 800000)) - 400000;
                cy = int'($urandom_range(0, 800000)) - 400000;
                a = make_near(cx, cy, sc);
                b = make_near(cx, cy, sc);
                if ($urandom_range(0, 99) < 30) begin
                    // butt b against a's far edge, within a pixel either way
                    reach = (a.kind == KIND_RECT) ? int'(a.sx) : 2 * int'(a.sx);
                    d = int'($urandom_range(0, 32)) - 16;
                    if ($urandom_range(0, 1)) begin
                        b.left = clamp_coord(longint'(a.left) + longint'(reach) +
                                             longint'(d));
                        b.top  = clamp_coord(longint'(a.top) +
                                             longint'($urandom_range(0, 64)) - longint'(32));
                    end else begin
                        b.top  = clamp_coord(longint'(a.top) + longint'(reach) +
                                             longint'(d));
                        b.left = clamp_coord(longint'(a.left) +
                                             longint'($urandom_range(0, 64)) - longint'(32));
                    end
                    if ($urandom_range(0, 1)) begin
                        t = a;
                        a = b;
                        b = t;
                    end
                end
            end
            send_shapes(a, b);
            idle_sender();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d pairs: %0d circle/circle, %0d box/box, %0d circle/box",
                 circle_pairs + box_pairs + mixed_pairs, circle_pairs, box_pairs, mixed_pairs);
        $display("checked %0d flag beats, %0d of them overlaps, %0d mismatches",
                 checked, hits, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
rtl/core/spot_pkg.sv
rtl/core/spot_front.sv
rtl/core/spot_queue.sv
rtl/core/spot_back.sv
rtl/core/shape_pair_overlap_test_top.sv
tb/sv/spot_tb_pkg.sv
tb/sv/spot_overlap_checker.sv
tb/sv/tb.sv
